[hdl/sst_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sst_pkg
// Shared field widths, operation and status codes, sequencer states and the
// per-cell control bundle of the scoped symbol table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned SCOPE_W  = 8;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_USED_W = STATUS_W + 1 + INDEX_W + VALUE_W + COUNT_W + SCOPE_W;
  localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 3'd0,
    FUNC_ADD    = 3'd1,
    FUNC_SET    = 3'd2,
    FUNC_ENTER  = 3'd3,
    FUNC_EXIT   = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_NOT_FOUND = 3'd1,
    STATUS_DUPLICATE = 3'd2,
    STATUS_FULL      = 3'd3,
    STATUS_SCOPE     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic wr_value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[hdl/scoped_symbol_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scoped_symbol_table
// Scoped symbol table held in a row of stack cells with a sequencer on top.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. The key is registered and broadcast
// to all cells, each cell registers its compare, and a registered priority
// tree of clog2(TABLE_DEPTH) levels picks the newest match; the result enters
// the output register once that is free. Exit scope first pops the entries of
// the current scope from the top cell, one per cycle. A finished result waits
// in the output register while the next transfer is taken. Searches run
// newest first, so inner scopes shadow outer ones; errors return a status
// code and leave the state unchanged.
module scoped_symbol_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned MAX_SCOPE   = 255
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] key, [63:32] new_value
  input  logic [sst_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [2:0] func
  input  logic [sst_pkg::FUNC_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] status, [3] found, [9:4] entry_index, [41:10] read_value,
  // [48:42] entry_count, [56:49] scope_now, [63:57] zero
  output logic [sst_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import sst_pkg::*;

  localparam int unsigned POS_BITS   = $clog2(TABLE_DEPTH);
  localparam int unsigned FILL_BITS  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SCOPE_BITS = $clog2(MAX_SCOPE + 1);
  localparam int unsigned WAIT_LAST  = POS_BITS + 1;
  localparam int unsigned WAIT_BITS  = $clog2(WAIT_LAST + 1);

  state_e                state_q, state_d;
  logic [FILL_BITS-1:0]  fill_q, fill_d;
  logic [SCOPE_BITS-1:0] scope_q, scope_d;
  logic [WAIT_BITS-1:0]  wait_q, wait_d;
  logic [FUNC_W-1:0]     func_q, func_d;
  logic [KEY_BITS-1:0]   query_q, query_d;
  logic [VALUE_W-1:0]    nv_q, nv_d;
  logic                  scope_err_q, scope_err_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_USED_W-1:0] out_data_q, out_data_d;

  cell_ctrl_t            ctrl;
  logic                  c_valid [TABLE_DEPTH];
  logic [KEY_BITS-1:0]   c_key   [TABLE_DEPTH];
  logic [VALUE_W-1:0]    c_value [TABLE_DEPTH];
  logic [SCOPE_BITS-1:0] c_scope [TABLE_DEPTH];
  logic                  c_hit   [TABLE_DEPTH];

  logic                  t_hit;
  logic [POS_BITS-1:0]   t_pos;
  logic [VALUE_W-1:0]    t_value;
  logic [SCOPE_BITS-1:0] t_scope;

  logic [FILL_BITS-1:0]  hit_index;
  logic [STATUS_W-1:0]   o_status;
  logic                  o_found;
  logic [INDEX_W-1:0]    o_index;
  logic [VALUE_W-1:0]    o_value;

  for (genvar p = 0; p < TABLE_DEPTH; p++) begin : g_cell
    logic                  pv, nv;
    logic [KEY_BITS-1:0]   pk, nk;
    logic [VALUE_W-1:0]    pval, nval;
    logic [SCOPE_BITS-1:0] ps, ns;

    if (p == 0) begin : g_head
      assign pv   = 1'b1;
      assign pk   = query_q;
      assign pval = '0;
      assign ps   = scope_q;
    end else begin : g_body
      assign pv   = c_valid[p-1];
      assign pk   = c_key[p-1];
      assign pval = c_value[p-1];
      assign ps   = c_scope[p-1];
    end

    if (p == TABLE_DEPTH - 1) begin : g_tail
      assign nv   = 1'b0;
      assign nk   = '0;
      assign nval = '0;
      assign ns   = '0;
    end else begin : g_inner
      assign nv   = c_valid[p+1];
      assign nk   = c_key[p+1];
      assign nval = c_value[p+1];
      assign ns   = c_scope[p+1];
    end

    sst_cell #(
      .KEY_BITS   (KEY_BITS),
      .SCOPE_BITS (SCOPE_BITS),
      .POS_BITS   (POS_BITS),
      .POS        (p)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .wr_pos_i     (t_pos),
      .wr_value_i   (nv_q),
      .query_i      (query_q),
      .prev_valid_i (pv),
      .prev_key_i   (pk),
      .prev_value_i (pval),
      .prev_scope_i (ps),
      .next_valid_i (nv),
      .next_key_i   (nk),
      .next_value_i (nval),
      .next_scope_i (ns),
      .valid_o      (c_valid[p]),
      .key_o        (c_key[p]),
      .value_o      (c_value[p]),
      .scope_o      (c_scope[p]),
      .hit_o        (c_hit[p])
    );
  end

  sst_find_tree #(
    .DEPTH      (TABLE_DEPTH),
    .SCOPE_BITS (SCOPE_BITS),
    .POS_BITS   (POS_BITS)
  ) u_find_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hit_i   (c_hit),
    .value_i (c_value),
    .scope_i (c_scope),
    .hit_o   (t_hit),
    .pos_o   (t_pos),
    .value_o (t_value),
    .scope_o (t_scope)
  );

  assign hit_index = fill_q - FILL_BITS'(1) - FILL_BITS'(t_pos);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    scope_d     = scope_q;
    wait_d      = wait_q;
    func_d      = func_q;
    query_d     = query_q;
    nv_d        = nv_q;
    scope_err_d = scope_err_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    ctrl        = '0;
    o_status    = STATUS_OK;
    o_found     = t_hit;
    o_index     = t_hit ? INDEX_W'(hit_index) : '0;
    o_value     = t_hit ? t_value : '0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          func_d      = s_axis_tuser;
          query_d     = KEY_BITS'(s_axis_tdata[KEY_W-1:0]);
          nv_d        = s_axis_tdata[KEY_W +: VALUE_W];
          scope_err_d = (scope_q == '0);
          wait_d      = '0;
          if ((s_axis_tuser == FUNC_EXIT) && (scope_q != '0)) begin
            state_d = ST_POP;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_POP: begin
        if (c_valid[0] && (c_scope[0] == scope_q)) begin
          ctrl.pop = 1'b1;
          fill_d   = fill_q - FILL_BITS'(1);
        end else begin
          scope_d = scope_q - SCOPE_BITS'(1);
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (wait_q != WAIT_BITS'(WAIT_LAST)) begin
          wait_d = wait_q + WAIT_BITS'(1);
        end else if (!out_valid_q || m_axis_tready) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          unique case (func_q)
            FUNC_LOOKUP: begin
              if (!t_hit) o_status = STATUS_NOT_FOUND;
            end
            FUNC_ADD: begin
              if (t_hit && (t_scope == scope_q)) begin
                o_status = STATUS_DUPLICATE;
              end else if (fill_q == FILL_BITS'(TABLE_DEPTH)) begin
                o_status = STATUS_FULL;
              end else begin
                ctrl.push = 1'b1;
                fill_d    = fill_q + FILL_BITS'(1);
                o_found   = 1'b1;
                o_index   = INDEX_W'(fill_q);
                o_value   = '0;
              end
            end
            FUNC_SET: begin
              if (t_hit) begin
                ctrl.wr_value = 1'b1;
                o_value       = nv_q;
              end else begin
                o_status = STATUS_NOT_FOUND;
              end
            end
            FUNC_ENTER: begin
              if (scope_q >= SCOPE_BITS'(MAX_SCOPE)) begin
                o_status = STATUS_SCOPE;
              end else begin
                scope_d = scope_q + SCOPE_BITS'(1);
              end
            end
            FUNC_EXIT: begin
              if (scope_err_q) o_status = STATUS_SCOPE;
            end
            default: begin
              o_status = STATUS_SCOPE;
            end
          endcase
          out_data_d = {SCOPE_W'(scope_d), COUNT_W'(fill_d), o_value, o_index, o_found,
                        o_status};
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      scope_q     <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      scope_q     <= scope_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    query_q     <= query_d;
    nv_q        <= nv_d;
    scope_err_q <= scope_err_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_data_q};

endmodule
`default_nettype wire

[hdl/sst_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sst_cell
// One stack slot. Position 0 holds the newest entry; a push moves every entry
// one cell down the row, a pop moves every entry one cell up.
// ----------------------------------------------------------------------------
module sst_cell #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned SCOPE_BITS = 8,
  parameter int unsigned POS_BITS   = 6,
  parameter int unsigned POS        = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sst_pkg::cell_ctrl_t            ctrl_i,
  input  logic [POS_BITS-1:0]            wr_pos_i,
  input  logic [sst_pkg::VALUE_W-1:0]    wr_value_i,
  input  logic [KEY_BITS-1:0]            query_i,
  input  logic                           prev_valid_i,
  input  logic [KEY_BITS-1:0]            prev_key_i,
  input  logic [sst_pkg::VALUE_W-1:0]    prev_value_i,
  input  logic [SCOPE_BITS-1:0]          prev_scope_i,
  input  logic                           next_valid_i,
  input  logic [KEY_BITS-1:0]            next_key_i,
  input  logic [sst_pkg::VALUE_W-1:0]    next_value_i,
  input  logic [SCOPE_BITS-1:0]          next_scope_i,
  output logic                           valid_o,
  output logic [KEY_BITS-1:0]            key_o,
  output logic [sst_pkg::VALUE_W-1:0]    value_o,
  output logic [SCOPE_BITS-1:0]          scope_o,
  output logic                           hit_o
);
  import sst_pkg::*;

  logic                  valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_W-1:0]    value_q, value_d;
  logic [SCOPE_BITS-1:0] scope_q, scope_d;
  logic                  hit_q, hit_d;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    scope_d = scope_q;
    priority if (ctrl_i.push) begin
      valid_d = prev_valid_i;
      key_d   = prev_key_i;
      value_d = prev_value_i;
      scope_d = prev_scope_i;
    end else if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      key_d   = next_key_i;
      value_d = next_value_i;
      scope_d = next_scope_i;
    end else if (ctrl_i.wr_value && (wr_pos_i == POS_BITS'(POS))) begin
      value_d = wr_value_i;
    end
    hit_d = valid_q && (key_q == query_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    scope_q <= scope_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;
  assign scope_o = scope_q;
  assign hit_o   = hit_q;

endmodule
`default_nettype wire

[hdl/sst_find_tree.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sst_find_tree
// Registered priority tree over the cell hit flags. The lowest position wins,
// which is the newest matching entry. One register level per tree level.
// ----------------------------------------------------------------------------
module sst_find_tree #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned SCOPE_BITS = 8,
  parameter int unsigned POS_BITS   = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        hit_i   [DEPTH],
  input  logic [sst_pkg::VALUE_W-1:0] value_i [DEPTH],
  input  logic [SCOPE_BITS-1:0]       scope_i [DEPTH],
  output logic                        hit_o,
  output logic [POS_BITS-1:0]         pos_o,
  output logic [sst_pkg::VALUE_W-1:0] value_o,
  output logic [SCOPE_BITS-1:0]       scope_o
);
  import sst_pkg::*;

  localparam int unsigned LEVELS = POS_BITS;
  localparam int unsigned LEAVES = 1 << LEVELS;

  logic                  node_hit   [LEVELS+1][LEAVES];
  logic [POS_BITS-1:0]   node_pos   [LEVELS+1][LEAVES];
  logic [VALUE_W-1:0]    node_value [LEVELS+1][LEAVES];
  logic [SCOPE_BITS-1:0] node_scope [LEVELS+1][LEAVES];

  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < DEPTH) begin : g_used
      assign node_hit[0][i]   = hit_i[i];
      assign node_value[0][i] = value_i[i];
      assign node_scope[0][i] = scope_i[i];
    end else begin : g_pad
      assign node_hit[0][i]   = 1'b0;
      assign node_value[0][i] = '0;
      assign node_scope[0][i] = '0;
    end
    assign node_pos[0][i] = POS_BITS'(i);
  end

  for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_level
    for (genvar j = 0; j < (LEAVES >> lv); j++) begin : g_node
      logic sel_left;
      assign sel_left = node_hit[lv-1][2*j];

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          node_hit[lv][j] <= 1'b0;
        end else begin
          node_hit[lv][j] <= node_hit[lv-1][2*j] | node_hit[lv-1][2*j+1];
        end
      end

      always_ff @(posedge clk_i) begin
        node_pos[lv][j]   <= sel_left ? node_pos[lv-1][2*j]   : node_pos[lv-1][2*j+1];
        node_value[lv][j] <= sel_left ? node_value[lv-1][2*j] : node_value[lv-1][2*j+1];
        node_scope[lv][j] <= sel_left ? node_scope[lv-1][2*j] : node_scope[lv-1][2*j+1];
      end
    end
  end

  assign hit_o   = node_hit[LEVELS][0];
  assign pos_o   = node_pos[LEVELS][0];
  assign value_o = node_value[LEVELS][0];
  assign scope_o = node_scope[LEVELS][0];

endmodule
`default_nettype wire
